@@ hw/rtl/kce_pkg.sv @@
`timescale 1ns / 1ps

package kce_pkg;

   // Default sizing
   localparam int KEY_SLOTS_DEF     = 64;
   localparam int FRACTION_BITS_DEF = 16;

   // Fixed field widths
   localparam int TIME_W      = 32;
   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 3;
   localparam int SLOT_W      = 6;
   localparam int KEY_COUNT_W = 7;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index (paddr[2])
   localparam logic REG_KEY_COUNT = 1'b0;

   typedef enum logic [1:0] {
      CMD_WRITE_KEY = 2'd0,
      CMD_SET_VALUE = 2'd1,
      CMD_SET_MODE  = 2'd2,
      CMD_EVALUATE  = 2'd3
   } cmd_type;

   // Interpolation modes; codes not listed interpolate linearly
   localparam logic [MODE_W-1:0] MODE_HOLD        = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EASE_IN     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_EASE_OUT    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EASE_IN_OUT = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_FIRST,
      ST_LAST,
      ST_EDGE,
      ST_SCAN,
      ST_SEG,
      ST_DIV,
      ST_SQUARE,
      ST_WEIGHT,
      ST_BLEND_MUL,
      ST_BLEND_SUM,
      ST_RESULT
   } state_type;

endpackage

@@ hw/rtl/kce_frac_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: floor((numer << FB) / denom)
// for numer <= denom, so the quotient fits in FB+1 bits.
module kce_frac_div #(
   parameter int FRACTION_BITS = kce_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [kce_pkg::TIME_W-1:0]        numer,
   input  logic [kce_pkg::TIME_W-1:0]        denom,
   output logic                              done,
   output logic [FRACTION_BITS:0]            quotient
);

   localparam int CNT_W = $clog2(FRACTION_BITS + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [kce_pkg::TIME_W:0]   rem_ff, rem_in;
   logic [kce_pkg::TIME_W-1:0] den_ff, den_in;
   logic [FRACTION_BITS:0]     quo_ff, quo_in;

   logic                       fits;
   logic [kce_pkg::TIME_W:0]   rem_next;

   always_comb begin
      fits     = rem_ff >= {1'b0, den_ff};
      rem_next = fits ? (rem_ff - {1'b0, den_ff}) : rem_ff;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRACTION_BITS);
         rem_in  = {1'b0, numer};
         den_in  = denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shift cannot overflow
         rem_in = {rem_next[kce_pkg::TIME_W-1:0], 1'b0};
         quo_in = {quo_ff[FRACTION_BITS-1:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/keyframe_curve_evaluator.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/tready      tuser command, tdata key fields
// rsp_      out        rsp_tvalid/tready      tdata curve_value
// csr_      in (APB)   psel/penable, pready=1 key_count at byte address 0
//
// An evaluate on an empty table returns zero, one at or beyond a table edge the edge value;
// else it runs the serial segment search (one table entry per cycle through the single read
// port), then, unless the segment is held or of zero length, the one-bit-per-cycle fraction
// divider and one pass through the shared multiplier, two for the eased modes.
// Synchronous reset clears key_count and control state; the key table has no reset.
// A result waiting in the output register stalls only the next result.
module keyframe_curve_evaluator #(
   parameter int KEY_SLOTS     = kce_pkg::KEY_SLOTS_DEF,
   parameter int FRACTION_BITS = kce_pkg::FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [79:0]                        req_tdata,  // slot[5:0], sample_time[37:6],
                                                          // key_value[69:38], key_mode[72:70]
   input  logic [1:0]                         req_tuser,  // command[1:0]
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,  // curve_value[31:0]
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kce_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [kce_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [kce_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int IW = $clog2(KEY_SLOTS);
   localparam int FB = FRACTION_BITS;
   localparam int TW = kce_pkg::TIME_W;
   localparam int VW = kce_pkg::VALUE_W;
   localparam int MW = kce_pkg::MODE_W;
   localparam int KW = kce_pkg::KEY_COUNT_W;
   localparam int PW = VW + 1 + FB + 2;   // shared multiplier product width

   localparam logic [FB:0] FRAC_ONE  = {1'b1, {FB{1'b0}}};
   localparam logic [FB:0] FRAC_HALF = {2'b01, {(FB - 1){1'b0}}};

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [KW-1:0] key_count_ff, key_count_in;
   logic          csr_we;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == kce_pkg::REG_KEY_COUNT);

   always_comb begin
      key_count_in = key_count_ff;
      if (csr_we) begin
         // saturate the count to the table depth
         if ({{(32 - KW){1'b0}}, csr_pwdata[KW-1:0]} > 32'(KEY_SLOTS)) begin
            key_count_in = KW'(KEY_SLOTS);
         end else begin
            key_count_in = csr_pwdata[KW-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == kce_pkg::REG_KEY_COUNT) ?
                       {{(kce_pkg::CSR_DATA_W - KW){1'b0}}, key_count_ff} : '0;

   // ---------------------------------------------------------------------
   // Key table: one write port, one registered read port
   // ---------------------------------------------------------------------
   logic [TW-1:0] time_mem  [KEY_SLOTS];
   logic [VW-1:0] value_mem [KEY_SLOTS];
   logic [MW-1:0] mode_mem  [KEY_SLOTS];

   logic [TW-1:0] time_rd_ff;
   logic [VW-1:0] value_rd_ff;
   logic [MW-1:0] mode_rd_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          we_time, we_value, we_mode;

   // ---------------------------------------------------------------------
   // Transaction and datapath registers
   // ---------------------------------------------------------------------
   kce_pkg::state_type state_ff, state_in;

   kce_pkg::cmd_type   cmd_ff;
   logic [kce_pkg::SLOT_W-1:0] slot_ff;
   logic [TW-1:0]      qtime_ff;
   logic [VW-1:0]      kval_ff;
   logic [MW-1:0]      kmode_ff;

   logic [TW-1:0]      prev_t_ff;
   logic [VW-1:0]      prev_v_ff;
   logic [MW-1:0]      prev_m_ff;
   logic [IW-1:0]      scan_ff;

   logic [TW-1:0]      diff_ff;     // query time minus segment start
   logic [TW-1:0]      dt_ff;       // segment length
   logic [VW-1:0]      v0_ff;
   logic signed [VW:0] vdiff_ff;    // v1 - v0
   logic [MW-1:0]      mode_ff;
   logic [FB:0]        t_ff;
   logic [FB:0]        w_ff;
   logic [VW-1:0]      res_ff;

   logic               rsp_tvalid_ff;
   logic [VW-1:0]      rsp_tdata_ff;

   // ---------------------------------------------------------------------
   // Shared multiplier and fraction divider
   // ---------------------------------------------------------------------
   logic signed [VW:0]   mul_a;
   logic signed [FB+1:0] mul_b;
   logic signed [PW-1:0] mul_ff;

   logic        div_start;
   logic        div_done;
   logic [FB:0] div_quo;

   kce_frac_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (diff_ff),
      .denom    (dt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------
   // Decode helpers
   // ---------------------------------------------------------------------
   logic              req_fire;
   kce_pkg::cmd_type  req_cmd;
   logic [IW-1:0]     last_idx;
   logic              single_key;
   logic              slot_ok;
   logic              seg_hit;
   logic              scan_end;
   logic              seg_trivial;
   logic              eased;
   logic              use_u;
   logic [FB:0]       u_val;
   logic [FB:0]       sq_op;
   logic [2*FB:0]     sq_w;
   logic [FB:0]       w_eased;
   logic              rsp_free;

   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = kce_pkg::cmd_type'(req_tuser);
   assign last_idx   = IW'(key_count_ff - KW'(1));
   assign single_key = key_count_ff == KW'(1);
   assign slot_ok    = {1'b0, slot_ff} < key_count_ff;
   assign seg_hit    = (qtime_ff >= prev_t_ff) && (qtime_ff <= time_rd_ff);
   assign scan_end   = scan_ff == last_idx;
   assign seg_trivial = (dt_ff == '0) || (mode_ff == kce_pkg::MODE_HOLD);
   assign eased      = (mode_ff == kce_pkg::MODE_EASE_IN) ||
                       (mode_ff == kce_pkg::MODE_EASE_OUT) ||
                       (mode_ff == kce_pkg::MODE_EASE_IN_OUT);
   assign u_val      = FRAC_ONE - t_ff;
   assign use_u      = (mode_ff == kce_pkg::MODE_EASE_OUT) ||
                       ((mode_ff == kce_pkg::MODE_EASE_IN_OUT) && (t_ff >= FRAC_HALF));
   assign sq_op      = use_u ? u_val : t_ff;
   assign sq_w       = mul_ff[2*FB:0];
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // weight from the registered square
   always_comb begin
      unique case (mode_ff)
         kce_pkg::MODE_EASE_IN:  w_eased = sq_w[2*FB:FB];
         kce_pkg::MODE_EASE_OUT: w_eased = FRAC_ONE - sq_w[2*FB:FB];
         kce_pkg::MODE_EASE_IN_OUT: begin
            if (t_ff < FRAC_HALF) begin
               w_eased = sq_w[2*FB-1:FB-1];
            end else begin
               w_eased = FRAC_ONE - sq_w[2*FB-1:FB-1];
            end
         end
         default: w_eased = t_ff;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kce_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd != kce_pkg::CMD_EVALUATE) begin
                  state_in = kce_pkg::ST_WRITE;
               end else if (key_count_ff == '0) begin
                  state_in = kce_pkg::ST_RESULT;
               end else begin
                  state_in = kce_pkg::ST_FIRST;
               end
            end
         end
         kce_pkg::ST_WRITE: state_in = kce_pkg::ST_IDLE;
         kce_pkg::ST_FIRST: state_in = kce_pkg::ST_LAST;
         kce_pkg::ST_LAST:  state_in = kce_pkg::ST_EDGE;
         kce_pkg::ST_EDGE: begin
            priority if (single_key || (qtime_ff <= prev_t_ff)) begin
               state_in = kce_pkg::ST_RESULT;
            end else if (qtime_ff >= time_rd_ff) begin
               state_in = kce_pkg::ST_RESULT;
            end else begin
               state_in = kce_pkg::ST_SCAN;
            end
         end
         kce_pkg::ST_SCAN: begin
            if (seg_hit) begin
               state_in = kce_pkg::ST_SEG;
            end else if (scan_end) begin
               state_in = kce_pkg::ST_RESULT;
            end
         end
         kce_pkg::ST_SEG: begin
            state_in = seg_trivial ? kce_pkg::ST_RESULT : kce_pkg::ST_DIV;
         end
         kce_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = eased ? kce_pkg::ST_SQUARE : kce_pkg::ST_BLEND_MUL;
            end
         end
         kce_pkg::ST_SQUARE:    state_in = kce_pkg::ST_WEIGHT;
         kce_pkg::ST_WEIGHT:    state_in = kce_pkg::ST_BLEND_MUL;
         kce_pkg::ST_BLEND_MUL: state_in = kce_pkg::ST_BLEND_SUM;
         kce_pkg::ST_BLEND_SUM: state_in = kce_pkg::ST_RESULT;
         kce_pkg::ST_RESULT: begin
            if (rsp_free) begin
               state_in = kce_pkg::ST_IDLE;
            end
         end
         default: state_in = kce_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      rd_addr    = '0;
      div_start  = 1'b0;
      we_time    = 1'b0;
      we_value   = 1'b0;
      we_mode    = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         kce_pkg::ST_IDLE: req_tready = 1'b1;
         kce_pkg::ST_WRITE: begin
            // drop writes beyond the active count
            if (slot_ok) begin
               we_time  = cmd_ff == kce_pkg::CMD_WRITE_KEY;
               we_value = (cmd_ff == kce_pkg::CMD_WRITE_KEY) ||
                          (cmd_ff == kce_pkg::CMD_SET_VALUE);
               we_mode  = (cmd_ff == kce_pkg::CMD_WRITE_KEY) ||
                          (cmd_ff == kce_pkg::CMD_SET_MODE);
            end
         end
         kce_pkg::ST_FIRST: rd_addr = '0;
         kce_pkg::ST_LAST:  rd_addr = last_idx;
         kce_pkg::ST_EDGE:  rd_addr = IW'(1);
         kce_pkg::ST_SCAN:  rd_addr = scan_ff + IW'(1);
         kce_pkg::ST_SEG:   div_start = !seg_trivial;
         kce_pkg::ST_SQUARE: begin
            mul_a = $signed({{(VW - FB){1'b0}}, sq_op});
            mul_b = $signed({1'b0, sq_op});
         end
         kce_pkg::ST_BLEND_MUL: begin
            mul_a = vdiff_ff;
            mul_b = $signed({1'b0, w_ff});
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Key table ports
   // ---------------------------------------------------------------------
   assign wr_addr = IW'(slot_ff);

   always_ff @(posedge clock) begin
      if (we_time) begin
         time_mem[wr_addr] <= qtime_ff;
      end
      if (we_value) begin
         value_mem[wr_addr] <= kval_ff;
      end
      if (we_mode) begin
         mode_mem[wr_addr] <= kmode_ff;
      end
      time_rd_ff  <= time_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
      mode_rd_ff  <= mode_mem[rd_addr];
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kce_pkg::ST_IDLE;
         key_count_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         if ((state_ff == kce_pkg::ST_RESULT) && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;

      if ((state_ff == kce_pkg::ST_RESULT) && rsp_free) begin
         rsp_tdata_ff <= res_ff;
      end

      unique case (state_ff)
         kce_pkg::ST_IDLE: begin
            // hold the transaction fields for the whole command
            cmd_ff   <= req_cmd;
            slot_ff  <= req_tdata[5:0];
            qtime_ff <= req_tdata[37:6];
            kval_ff  <= req_tdata[69:38];
            kmode_ff <= req_tdata[72:70];
            res_ff   <= '0;   // empty table
         end
         kce_pkg::ST_LAST: begin
            prev_t_ff <= time_rd_ff;
            prev_v_ff <= value_rd_ff;
            prev_m_ff <= mode_rd_ff;
         end
         kce_pkg::ST_EDGE: begin
            scan_ff <= IW'(1);
            if (single_key || (qtime_ff <= prev_t_ff)) begin
               res_ff <= prev_v_ff;
            end else begin
               res_ff <= value_rd_ff;
            end
         end
         kce_pkg::ST_SCAN: begin
            // capture the segment on a hit, else advance one entry
            diff_ff  <= qtime_ff - prev_t_ff;
            dt_ff    <= time_rd_ff - prev_t_ff;
            v0_ff    <= prev_v_ff;
            vdiff_ff <= $signed({value_rd_ff[VW-1], value_rd_ff}) -
                        $signed({prev_v_ff[VW-1], prev_v_ff});
            mode_ff  <= prev_m_ff;
            res_ff   <= value_rd_ff;
            if (!seg_hit) begin
               prev_t_ff <= time_rd_ff;
               prev_v_ff <= value_rd_ff;
               prev_m_ff <= mode_rd_ff;
               scan_ff   <= scan_ff + IW'(1);
            end
         end
         kce_pkg::ST_SEG: res_ff <= v0_ff;
         kce_pkg::ST_DIV: begin
            t_ff <= div_quo;
            w_ff <= div_quo;
         end
         kce_pkg::ST_WEIGHT: w_ff <= w_eased;
         kce_pkg::ST_BLEND_SUM: begin
            // floor of the product over ONE is the arithmetic shift
            res_ff <= v0_ff + mul_ff[FB +: VW];
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
